FILE: sv/sorted_max_score_table_defines.svh
// Assertion macros of the sorted max-score table RTL.
`ifndef SORTED_MAX_SCORE_TABLE_DEFINES_SVH
`define SORTED_MAX_SCORE_TABLE_DEFINES_SVH

// Checks a property on every clock edge outside reset.
`define SMST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition implies another in the same cycle.
`define SMST_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: sv/smst_pkg.sv
// Types and constants of the sorted max-score table.
`timescale 1ns / 1ps
`default_nettype none

package smst_pkg;

  localparam int unsigned PLAYER_KEY_W  = 16;
  localparam int unsigned SCORE_W       = 32;
  localparam int unsigned RANK_W        = 4;
  localparam int unsigned ENTRY_COUNT_W = 5;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_REMOVE,
    CELL_INSERT
  } cell_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_REMOVE,
    ST_INSERT,
    ST_DONE
  } smst_state_e;

  typedef struct packed {
    logic match;
    logic ge;
    logic take_new;
  } cell_stat_t;

endpackage

`default_nettype wire

FILE: sv/smst_in_if.sv
// Input channel of the sorted max-score table: key and submitted score.
`timescale 1ns / 1ps
`default_nettype none

interface smst_in_if import smst_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [PLAYER_KEY_W-1:0]   player_key;
  logic signed [SCORE_W-1:0] new_score;

  modport source (output valid, output player_key, output new_score, input ready);
  modport sink (input valid, input player_key, input new_score, output ready);
endinterface

`default_nettype wire

FILE: sv/smst_out_if.sv
// Result channel of the sorted max-score table.
`timescale 1ns / 1ps
`default_nettype none

interface smst_out_if import smst_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [RANK_W-1:0]          rank;
  logic signed [SCORE_W-1:0]  stored_score;
  logic                       was_new;
  logic                       dropped;
  logic [ENTRY_COUNT_W-1:0]   entry_count;

  modport source (output valid, output rank, output stored_score, output was_new,
                  output dropped, output entry_count, input ready);
  modport sink (input valid, input rank, input stored_score, input was_new,
                input dropped, input entry_count, output ready);
endinterface

`default_nettype wire

FILE: sv/smst_cell.sv
// One table cell: holds a key and score, compares them and shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module smst_cell import smst_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned KEY_WIDTH   = 16,
  parameter int unsigned CELL_INDEX  = 0,
  localparam int unsigned IDX_W      = $clog2(TABLE_DEPTH),
  localparam int unsigned CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic                      clk_i,
  input  wire cell_op_e                  op_i,
  input  wire logic [CNT_W-1:0]          count_i,
  input  wire logic [IDX_W-1:0]          idx_i,
  input  wire logic [KEY_WIDTH-1:0]      look_key_i,
  input  wire logic signed [SCORE_W-1:0] ins_score_i,
  input  wire logic [KEY_WIDTH-1:0]      left_key_i,
  input  wire logic signed [SCORE_W-1:0] left_score_i,
  input  wire logic                      left_ge_i,
  input  wire logic [KEY_WIDTH-1:0]      right_key_i,
  input  wire logic signed [SCORE_W-1:0] right_score_i,
  output logic [KEY_WIDTH-1:0]           key_o,
  output logic signed [SCORE_W-1:0]      score_o,
  output cell_stat_t                     stat_o
);

  logic [KEY_WIDTH-1:0]      key_q, key_d;
  logic signed [SCORE_W-1:0] score_q, score_d;
  logic                      valid;
  logic                      ge;
  logic                      take_new;
  logic                      at_or_after;

  assign valid       = CNT_W'(CELL_INDEX) < count_i;
  assign ge          = valid && (score_q >= ins_score_i);
  assign take_new    = !ge && left_ge_i;
  assign at_or_after = IDX_W'(CELL_INDEX) >= idx_i;

  always_comb begin
    key_d   = key_q;
    score_d = score_q;
    unique case (op_i)
      CELL_REMOVE: begin
        if (at_or_after) begin
          key_d   = right_key_i;
          score_d = right_score_i;
        end
      end
      CELL_INSERT: begin
        if (take_new) begin
          key_d   = look_key_i;
          score_d = ins_score_i;
        end else if (!ge) begin
          key_d   = left_key_i;
          score_d = left_score_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    score_q <= score_d;
  end

  assign key_o           = key_q;
  assign score_o         = score_q;
  assign stat_o.match    = valid && (key_q == look_key_i);
  assign stat_o.ge       = ge;
  assign stat_o.take_new = take_new;

endmodule

`default_nettype wire

FILE: sv/sorted_max_score_table.sv
// Sorted max-score table top level: control sequencer, cell row and result register.
//
// The table holds up to TABLE_DEPTH key/score entries in a row of cells, sorted by
// descending score, with an updated or inserted entry placed after entries of equal
// score. One transaction is worked at a time by a sequencer that steps the whole row
// in parallel: a lookup step in which every cell compares its key, a remove step in
// which the cells after a matching entry shift one place toward the head, and an
// insert step in which every cell compares its score and the row opens a gap at the
// sorted position. A present key passes lookup, remove, insert and done, a new key
// skips remove, and a key dropped on a full table goes from lookup straight to done.
// Results wait in an output register, so the next transaction is taken while a result
// is still pending; a new result waits only while the previous one is not taken.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_max_score_table_defines.svh"

module sorted_max_score_table import smst_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned KEY_WIDTH   = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  smst_in_if.sink     in_i,
  smst_out_if.source  out_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  smst_state_e state_q, state_d;
  cell_op_e    cell_op;

  logic [KEY_WIDTH-1:0]      key_q;
  logic signed [SCORE_W-1:0] score_q;
  logic signed [SCORE_W-1:0] stored_q;
  logic [IDX_W-1:0]          idx_q;
  logic [CNT_W-1:0]          count_q;
  logic [RANK_W-1:0]         rank_q;
  logic                      was_new_q;
  logic                      dropped_q;

  logic                      out_valid_q;
  logic [RANK_W-1:0]         out_rank_q;
  logic signed [SCORE_W-1:0] out_score_q;
  logic                      out_was_new_q;
  logic                      out_dropped_q;
  logic [ENTRY_COUNT_W-1:0]  out_count_q;

  logic [63:0]               in_key_ext;
  logic [KEY_WIDTH-1:0]      in_key;
  logic                      in_accept;
  logic                      out_load;

  logic [KEY_WIDTH-1:0]      cell_key   [TABLE_DEPTH];
  logic signed [SCORE_W-1:0] cell_score [TABLE_DEPTH];
  cell_stat_t                cell_stat  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]    match_vec;
  logic [TABLE_DEPTH-1:0]    take_vec;

  logic                      found;
  logic                      full;
  logic [IDX_W-1:0]          match_idx;
  logic [IDX_W-1:0]          ins_pos;
  logic signed [SCORE_W-1:0] old_score;
  logic signed [SCORE_W-1:0] upd_score;
  logic [31:0]               pos_ext;
  logic [31:0]               count_ext;

  assign in_key_ext = 64'(in_i.player_key);
  assign in_key     = in_key_ext[KEY_WIDTH-1:0];
  assign in_accept  = in_i.valid && in_i.ready;

  // The cell row.
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic [KEY_WIDTH-1:0]      left_key, right_key;
    logic signed [SCORE_W-1:0] left_score, right_score;
    logic                      left_ge;

    if (g == 0) begin : g_head
      assign left_key   = '0;
      assign left_score = '0;
      assign left_ge    = 1'b1;
    end else begin : g_body
      assign left_key   = cell_key[g-1];
      assign left_score = cell_score[g-1];
      assign left_ge    = cell_stat[g-1].ge;
    end

    if (g == TABLE_DEPTH - 1) begin : g_tail
      assign right_key   = '0;
      assign right_score = '0;
    end else begin : g_inner
      assign right_key   = cell_key[g+1];
      assign right_score = cell_score[g+1];
    end

    smst_cell #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_WIDTH   (KEY_WIDTH),
      .CELL_INDEX  (g)
    ) u_cell (
      .clk_i         (clk_i),
      .op_i          (cell_op),
      .count_i       (count_q),
      .idx_i         (idx_q),
      .look_key_i    (key_q),
      .ins_score_i   (stored_q),
      .left_key_i    (left_key),
      .left_score_i  (left_score),
      .left_ge_i     (left_ge),
      .right_key_i   (right_key),
      .right_score_i (right_score),
      .key_o         (cell_key[g]),
      .score_o       (cell_score[g]),
      .stat_o        (cell_stat[g])
    );

    assign match_vec[g] = cell_stat[g].match;
    assign take_vec[g]  = cell_stat[g].take_new;
  end

  always_comb begin
    match_idx = '0;
    ins_pos   = '0;
    old_score = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (cell_stat[i].match) begin
        match_idx = match_idx | IDX_W'(i);
        old_score = old_score | cell_score[i];
      end
      if (cell_stat[i].take_new) begin
        ins_pos = ins_pos | IDX_W'(i);
      end
    end
  end

  assign found     = |match_vec;
  assign full      = count_q == CNT_W'(TABLE_DEPTH);
  assign upd_score = (old_score > score_q) ? old_score : score_q;
  assign pos_ext   = 32'(ins_pos);
  assign count_ext = 32'(count_q);

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    cell_op  = CELL_HOLD;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        priority if (found) begin
          state_d = ST_REMOVE;
        end else if (full) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_INSERT;
        end
      end
      ST_REMOVE: begin
        cell_op = CELL_REMOVE;
        state_d = ST_INSERT;
      end
      ST_INSERT: begin
        cell_op = CELL_INSERT;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_i.ready = state_q == ST_IDLE;

  // Transaction registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      key_q   <= in_key;
      score_q <= in_i.new_score;
    end
    if (state_q == ST_LOOKUP) begin
      idx_q     <= match_idx;
      rank_q    <= '0;
      was_new_q <= !found && !full;
      dropped_q <= !found && full;
      if (found) begin
        stored_q <= upd_score;
      end else if (full) begin
        stored_q <= '0;
      end else begin
        stored_q <= score_q;
      end
    end
    if (state_q == ST_INSERT) begin
      rank_q <= pos_ext[RANK_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (state_q == ST_REMOVE) begin
      count_q <= count_q - CNT_W'(1);
    end else if (state_q == ST_INSERT) begin
      count_q <= count_q + CNT_W'(1);
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_rank_q    <= rank_q;
      out_score_q   <= stored_q;
      out_was_new_q <= was_new_q;
      out_dropped_q <= dropped_q;
      out_count_q   <= count_ext[ENTRY_COUNT_W-1:0];
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.rank         = out_rank_q;
  assign out_o.stored_score = out_score_q;
  assign out_o.was_new      = out_was_new_q;
  assign out_o.dropped      = out_dropped_q;
  assign out_o.entry_count  = out_count_q;

  // A key is held by at most one cell.
  `SMST_ASSERT(a_single_match, $onehot0(match_vec), "key held by more than one cell")
  // A sorted row opens exactly one gap on insertion.
  `SMST_ASSERT_IMP(a_one_gap, state_q == ST_INSERT, $onehot(take_vec), "insert gap not unique")
  // The entry count never passes the table depth.
  `SMST_ASSERT(a_count_range, count_q <= CNT_W'(TABLE_DEPTH), "entry count above depth")
  // A dropped transaction is reported only on a full table.
  `SMST_ASSERT_IMP(a_drop_full, state_q == ST_DONE && dropped_q, full, "drop without full table")

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench of the sorted max-score table with a ranking tracker and random stalls.
`timescale 1ns / 1ps

module testbench;
  import smst_pkg::*;

  localparam int TABLE_SLOTS    = 16;
  localparam int RANDOM_ITEMS   = 1150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF       = 300;
  localparam int HOLD_OFF_AFTER = 300;
  localparam int DRAIN_CYCLES   = 20;
  localparam int PRINT_LIMIT    = 40;

  typedef struct packed {
    logic [RANK_W-1:0]         rank;
    logic signed [SCORE_W-1:0] stored_score;
    logic                      was_new;
    logic                      dropped;
    logic [ENTRY_COUNT_W-1:0]  entry_count;
  } ranking_t;

  class ranking_tracker;
    logic [PLAYER_KEY_W-1:0]   held_keys [TABLE_SLOTS];
    logic signed [SCORE_W-1:0] held_scores [TABLE_SLOTS];
    int                        held_count;
    ranking_t                  expected_ranks [$];
    int                        mismatch_count;
    int                        checked_count;

    function new();
      held_count     = 0;
      mismatch_count = 0;
      checked_count  = 0;
    endfunction

    // The entry goes after every other entry whose score is greater or equal.
    function int place_entry(logic [PLAYER_KEY_W-1:0] key, logic signed [SCORE_W-1:0] score);
      int pos;
      pos = 0;
      while (pos < held_count && held_scores[pos] >= score) pos++;
      for (int i = held_count; i > pos; i--) begin
        held_keys[i]   = held_keys[i-1];
        held_scores[i] = held_scores[i-1];
      end
      held_keys[pos]   = key;
      held_scores[pos] = score;
      held_count++;
      return pos;
    endfunction

    function void note_entry(logic [PLAYER_KEY_W-1:0] key, logic signed [SCORE_W-1:0] score);
      ranking_t                  res;
      int                        idx;
      int                        pos;
      logic signed [SCORE_W-1:0] best;
      res = '0;
      idx = -1;
      for (int i = 0; i < held_count; i++) begin
        if (idx < 0 && held_keys[i] == key) idx = i;
      end
      if (idx >= 0) begin
        best = (held_scores[idx] > score) ? held_scores[idx] : score;
        for (int i = idx; i < held_count - 1; i++) begin
          held_keys[i]   = held_keys[i+1];
          held_scores[i] = held_scores[i+1];
        end
        held_count--;
        pos              = place_entry(key, best);
        res.rank         = RANK_W'(pos);
        res.stored_score = best;
      end else if (held_count >= TABLE_SLOTS) begin
        res.dropped = 1'b1;
      end else begin
        pos              = place_entry(key, score);
        res.rank         = RANK_W'(pos);
        res.stored_score = score;
        res.was_new      = 1'b1;
      end
      res.entry_count = ENTRY_COUNT_W'(held_count);
      expected_ranks.insert(expected_ranks.size(), res);
    endfunction

    task report_mismatch(string what, longint got, longint want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
        $display("ERROR at %0t ns: %s is %0d, expected %0d", $time, what, got, want);
      end
    endtask

    task check_ranking(ranking_t got);
      ranking_t want;
      checked_count++;
      if (expected_ranks.size() == 0) begin
        report_mismatch("unexpected transaction, rank", got.rank, 0);
        return;
      end
      want = expected_ranks.pop_front();
      if (got.rank !== want.rank) report_mismatch("rank", got.rank, want.rank);
      if (got.stored_score !== want.stored_score) begin
        report_mismatch("stored_score", $signed(got.stored_score), $signed(want.stored_score));
      end
      if (got.was_new !== want.was_new) report_mismatch("was_new", got.was_new, want.was_new);
      if (got.dropped !== want.dropped) report_mismatch("dropped", got.dropped, want.dropped);
      if (got.entry_count !== want.entry_count) begin
        report_mismatch("entry_count", got.entry_count, want.entry_count);
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  int   idle_cycles;
  bit   sender_calm;
  bit   receiver_calm;
  bit   hold_off_done;

  ranking_tracker tracker = new();

  smst_in_if  in_if ();
  smst_out_if out_if ();

  sorted_max_score_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  task automatic send_entry(logic [PLAYER_KEY_W-1:0] key, logic signed [SCORE_W-1:0] score);
    int unsigned gap;
    gap = pick_gap(sender_calm);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.player_key <= key;
    in_if.new_score  <= score;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic run_directed();
    send_entry(16'h0000, 32'sh7FFFFFFF);
    send_entry(16'hFFFF, 32'sh80000000);
    send_entry(16'h0001, 32'sd0);
    send_entry(16'h0002, 32'sd0);
    send_entry(16'h0001, -32'sd5);
    send_entry(16'h0001, 32'sh7FFFFFFF);
    send_entry(16'h0000, 32'sh80000000);
    for (int k = 3; k < 15; k++) begin
      send_entry(PLAYER_KEY_W'(k), SCORE_W'(k * 1000 - 6000));
    end
    send_entry(16'h8000, 32'sd123);
    send_entry(16'h5A5A, 32'sh80000000);
    send_entry(16'hFFFF, 32'sh7FFFFFFE);
  endtask

  task automatic run_random();
    logic [PLAYER_KEY_W-1:0]   key;
    logic signed [SCORE_W-1:0] score;
    int unsigned               r;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 39) == 0) sender_calm = ~sender_calm;
      r = $urandom_range(0, 99);
      if (r < 70) begin
        key = tracker.held_keys[$urandom_range(0, tracker.held_count - 1)];
      end else if (r < 80) begin
        key = tracker.held_keys[$urandom_range(0, tracker.held_count - 1)]
              ^ (PLAYER_KEY_W'(1) << $urandom_range(0, PLAYER_KEY_W - 1));
      end else begin
        key = PLAYER_KEY_W'($urandom);
      end
      case ($urandom_range(0, 9))
        0, 1, 2: score = $urandom;
        3, 4: score = SCORE_W'($urandom_range(0, 8)) - 32'sd4;
        5, 6: score = tracker.held_scores[$urandom_range(0, tracker.held_count - 1)];
        7: begin
          case ($urandom_range(0, 3))
            0: score = 32'sh7FFFFFFF;
            1: score = 32'sh80000000;
            2: score = 32'sh7FFFFFFE;
            default: score = 32'sh80000001;
          endcase
        end
        default: begin
          score = tracker.held_scores[$urandom_range(0, tracker.held_count - 1)]
                  + SCORE_W'($urandom_range(0, 4)) - 32'sd2;
        end
      endcase
      send_entry(key, score);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) tracker.note_entry(in_if.player_key, in_if.new_score);
      if (out_if.valid && out_if.ready) begin
        tracker.check_ranking('{rank: out_if.rank, stored_score: out_if.stored_score,
                                was_new: out_if.was_new, dropped: out_if.dropped,
                                entry_count: out_if.entry_count});
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // The receiver stalls at random and, once, long enough for the block to back up.
  initial begin
    int unsigned hold;
    out_if.ready  = 1'b0;
    receiver_calm = 1'b0;
    hold_off_done = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (!hold_off_done && tracker.checked_count >= HOLD_OFF_AFTER) begin
        hold_off_done = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_OFF) @(negedge clk_i);
      end else begin
        if ($urandom_range(0, 19) == 0) receiver_calm = ~receiver_calm;
        hold = pick_gap(receiver_calm);
        if (hold > 0) begin
          out_if.ready <= 1'b0;
          repeat (hold) @(negedge clk_i);
        end
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
    end
  end

  initial begin
    in_if.valid      = 1'b0;
    in_if.player_key = '0;
    in_if.new_score  = '0;
    sender_calm      = 1'b0;
    rst_ni           = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    run_directed();
    run_random();
    in_if.valid <= 1'b0;
    while (tracker.expected_ranks.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.expected_ranks.size() != 0) begin
      tracker.report_mismatch("transactions still missing", tracker.expected_ranks.size(), 0);
    end
    if (tracker.mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
